// File: sv/itoa_pkg.sv
package itoa_pkg;

    localparam int NUM_DIGITS = 20;
    localparam int DIG_W      = 4 * NUM_DIGITS;
    localparam int VAL_W      = 64;

    localparam logic [1:0] FUNC_SDEC = 2'd0;
    localparam logic [1:0] FUNC_UDEC = 2'd1;
    localparam logic [1:0] FUNC_HEX  = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam logic [1:0] WMODE_16  = 2'd0;
    localparam logic [1:0] WMODE_32  = 2'd1;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  width_mode;
        logic [63:0] number;
    } item_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_PFX0,
        ST_PFXX,
        ST_DIGIT
    } state_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
        begin
            ch = CHAR_ZERO + {4'd0, nib};
        end
        else
        begin
            ch = CHAR_UPPER + {4'd0, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage

// File: sv/integer_to_ascii_formatter.sv
// Formats one number per start beat as ASCII text, most significant character first, one
// character per strobe. Decimal runs a bit-serial double-dabble, one operand bit per cycle,
// while hex loads its digits directly; leading zero digits are then dropped one per cycle
// (up to 19), and sign or "0x" prefix and digits leave one per cycle. Busy drops in the
// cycle that carries the last character, so the next start beat can be taken there. The
// receiver cannot stall: each character appears for exactly one cycle with strobe high,
// and last_char marks the final one. A format code of 3 is accepted and produces no text.
module integer_to_ascii_formatter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  itoa_pkg::item_t   item,
    output logic              busy,
    output logic              strobe,
    output itoa_pkg::result_t result
);

    itoa_pkg::state_t state_reg, state_next;

    logic [itoa_pkg::DIG_W-1:0] dig_reg, dig_next;
    logic [itoa_pkg::VAL_W-1:0] bin_reg, bin_next;
    logic [6:0]                 cnt_reg, cnt_next;
    logic [4:0]                 dcnt_reg, dcnt_next;
    logic                       neg_reg, neg_next;
    logic                       hex_reg, hex_next;
    logic                       strobe_reg, strobe_next;
    itoa_pkg::result_t          result_reg, result_next;

    logic [itoa_pkg::VAL_W-1:0] val_masked;
    logic [itoa_pkg::VAL_W-1:0] val_mag;
    logic [itoa_pkg::VAL_W-1:0] val_aligned;
    logic [6:0]                 val_bits;
    logic                       val_sign;
    logic                       load_neg;
    logic [itoa_pkg::DIG_W-1:0] dig_adj;

    // Operand selection by width
    always_comb
    begin
        unique case (item.width_mode)
            itoa_pkg::WMODE_16:
            begin
                val_masked = {48'd0, item.number[15:0]};
                val_sign   = item.number[15];
                val_bits   = 7'd16;
            end
            itoa_pkg::WMODE_32:
            begin
                val_masked = {32'd0, item.number[31:0]};
                val_sign   = item.number[31];
                val_bits   = 7'd32;
            end
            default:
            begin
                val_masked = item.number;
                val_sign   = item.number[63];
                val_bits   = 7'd64;
            end
        endcase
    end

    assign load_neg = (item.func == itoa_pkg::FUNC_SDEC) && val_sign;

    always_comb
    begin
        logic [itoa_pkg::VAL_W-1:0] negated;
        negated = ~val_masked + 64'd1;
        if (load_neg)
        begin
            unique case (item.width_mode)
                itoa_pkg::WMODE_16: val_mag = {48'd0, negated[15:0]};
                itoa_pkg::WMODE_32: val_mag = {32'd0, negated[31:0]};
                default:            val_mag = negated;
            endcase
        end
        else
        begin
            val_mag = val_masked;
        end
    end

    // Left-align so the operand MSB sits at bit 63 for the serial shift
    always_comb
    begin
        unique case (item.width_mode)
            itoa_pkg::WMODE_16: val_aligned = {val_mag[15:0], 48'd0};
            itoa_pkg::WMODE_32: val_aligned = {val_mag[31:0], 32'd0};
            default:            val_aligned = val_mag;
        endcase
    end

    // Double-dabble add-3 on every BCD digit
    always_comb
    begin
        for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++)
        begin
            if (dig_reg[4*i +: 4] >= 4'd5)
            begin
                dig_adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                dig_adj[4*i +: 4] = dig_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        dig_next    = dig_reg;
        bin_next    = bin_reg;
        cnt_next    = cnt_reg;
        dcnt_next   = dcnt_reg;
        neg_next    = neg_reg;
        hex_next    = hex_reg;
        strobe_next = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (start && (item.func != itoa_pkg::FUNC_NONE))
                begin
                    neg_next  = load_neg;
                    hex_next  = (item.func == itoa_pkg::FUNC_HEX);
                    dcnt_next = 5'(itoa_pkg::NUM_DIGITS);
                    bin_next  = val_aligned;
                    cnt_next  = val_bits;
                    if (item.func == itoa_pkg::FUNC_HEX)
                    begin
                        dig_next   = {16'd0, val_masked};
                        state_next = itoa_pkg::ST_SKIP;
                    end
                    else
                    begin
                        dig_next   = '0;
                        state_next = itoa_pkg::ST_CONV;
                    end
                end
            end
            itoa_pkg::ST_CONV:
            begin
                dig_next = {dig_adj[itoa_pkg::DIG_W-2:0], bin_reg[itoa_pkg::VAL_W-1]};
                bin_next = {bin_reg[itoa_pkg::VAL_W-2:0], 1'b0};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    state_next = itoa_pkg::ST_SKIP;
                end
            end
            itoa_pkg::ST_SKIP:
            begin
                if ((dig_reg[itoa_pkg::DIG_W-1 -: 4] == 4'd0) && (dcnt_reg != 5'd1))
                begin
                    dig_next  = {dig_reg[itoa_pkg::DIG_W-5:0], 4'd0};
                    dcnt_next = dcnt_reg - 5'd1;
                end
                else if (neg_reg)
                begin
                    state_next = itoa_pkg::ST_SIGN;
                end
                else if (hex_reg)
                begin
                    state_next = itoa_pkg::ST_PFX0;
                end
                else
                begin
                    state_next = itoa_pkg::ST_DIGIT;
                end
            end
            itoa_pkg::ST_SIGN:
            begin
                strobe_next           = 1'b1;
                result_next.text_char = itoa_pkg::CHAR_MINUS;
                result_next.last_char = 1'b0;
                state_next            = itoa_pkg::ST_DIGIT;
            end
            itoa_pkg::ST_PFX0:
            begin
                strobe_next           = 1'b1;
                result_next.text_char = itoa_pkg::CHAR_ZERO;
                result_next.last_char = 1'b0;
                state_next            = itoa_pkg::ST_PFXX;
            end
            itoa_pkg::ST_PFXX:
            begin
                strobe_next           = 1'b1;
                result_next.text_char = itoa_pkg::CHAR_X;
                result_next.last_char = 1'b0;
                state_next            = itoa_pkg::ST_DIGIT;
            end
            itoa_pkg::ST_DIGIT:
            begin
                strobe_next           = 1'b1;
                result_next.text_char = itoa_pkg::hex_char(dig_reg[itoa_pkg::DIG_W-1 -: 4]);
                result_next.last_char = (dcnt_reg == 5'd1);
                dig_next              = {dig_reg[itoa_pkg::DIG_W-5:0], 4'd0};
                dcnt_next             = dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd1)
                begin
                    state_next = itoa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= itoa_pkg::ST_IDLE;
            strobe_reg <= 1'b0;
            cnt_reg    <= '0;
            dcnt_reg   <= '0;
            neg_reg    <= 1'b0;
            hex_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            cnt_reg    <= cnt_next;
            dcnt_reg   <= dcnt_next;
            neg_reg    <= neg_next;
            hex_reg    <= hex_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg    <= dig_next;
        bin_reg    <= bin_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != itoa_pkg::ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // The final character always shows once the block is free again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last_char |-> !busy)
        else $error("last character seen while still busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.func != itoa_pkg::FUNC_NONE) |=> busy)
        else $error("valid start beat did not raise busy");

    a_conv_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itoa_pkg::ST_CONV) |-> !strobe)
        else $error("character strobe during conversion");

    a_digit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itoa_pkg::ST_DIGIT) |-> (dcnt_reg != 5'd0))
        else $error("digit emission with no digits left");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] WMODE_64   = 2'd2;
    localparam logic [1:0] WMODE_RSVD = 2'd3;
    localparam int IDLE_LOW    = 13;
    localparam int IDLE_HIGH   = 65;
    localparam int IDLE_NONE   = 0;
    localparam int PHASE_ITEMS = 50;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    // Predicts the character stream of each accepted number and checks the strobed output.
    class text_tracker;
        itoa_pkg::result_t pending_chars[$];
        int      mismatches = 0;

        function void note_number(itoa_pkg::item_t it);
            logic [63:0] mask;
            logic [63:0] val;
            logic [63:0] radix;
            logic [63:0] rem;
            logic [7:0]  dig;
            logic [7:0]  text[$];
            logic        neg;
            itoa_pkg::result_t r;
            if (it.func == itoa_pkg::FUNC_NONE)
                return;
            case (it.width_mode)
                itoa_pkg::WMODE_16: mask = 64'h0000_0000_0000_FFFF;
                itoa_pkg::WMODE_32: mask = 64'h0000_0000_FFFF_FFFF;
                default:  mask = '1;
            endcase
            val = it.number & mask;
            neg = (it.func == itoa_pkg::FUNC_SDEC) && ((val & ~(mask >> 1)) != 64'd0);
            // magnitude at operand width, so the most negative value maps onto itself unsigned
            if (neg)
                val = (~val + 64'd1) & mask;
            radix = (it.func == itoa_pkg::FUNC_HEX) ? 64'd16 : 64'd10;
            do
            begin
                rem = val % radix;
                dig = rem[7:0];
                text.push_front((dig < 8'd10) ? itoa_pkg::CHAR_ZERO + dig
                                              : itoa_pkg::CHAR_UPPER + dig - 8'd10);
                val = val / radix;
            end
            while (val != 64'd0);
            if (it.func == itoa_pkg::FUNC_HEX)
            begin
                text.push_front(itoa_pkg::CHAR_X);
                text.push_front(itoa_pkg::CHAR_ZERO);
            end
            if (neg)
                text.push_front(itoa_pkg::CHAR_MINUS);
            foreach (text[k])
            begin
                r.text_char = text[k];
                r.last_char = (k == text.size() - 1);
                pending_chars.push_back(r);
            end
        endfunction

        function void check_char(itoa_pkg::result_t got);
            itoa_pkg::result_t want;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character: text_char 0x%02h last_char %0b",
                       got.text_char, got.last_char);
                mismatches++;
                return;
            end
            want = pending_chars.pop_front();
            if (got.text_char !== want.text_char)
            begin
                $error("text_char: expected 0x%02h actual 0x%02h",
                       want.text_char, got.text_char);
                mismatches++;
            end
            if (got.last_char !== want.last_char)
            begin
                $error("last_char: expected %0b actual %0b", want.last_char, got.last_char);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    itoa_pkg::item_t   item  = '0;
    logic              busy;
    logic              strobe;
    itoa_pkg::result_t result;

    text_tracker tracker;
    int          cycle_count = 0;

    integer_to_ascii_formatter i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
            tracker.check_char(result);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic itoa_pkg::item_t make_item(logic [1:0] f, logic [1:0] wm,
                                                  logic [63:0] num);
        itoa_pkg::item_t it;
        it.func       = f;
        it.width_mode = wm;
        it.number     = num;
        return it;
    endfunction

    function automatic itoa_pkg::item_t random_item();
        itoa_pkg::item_t it;
        int          w;
        logic [63:0] msb;
        logic [63:0] noise;
        it.func       = ($urandom_range(19) == 0) ? itoa_pkg::FUNC_NONE : 2'($urandom_range(2));
        it.width_mode = 2'($urandom_range(3));
        noise         = {$urandom, $urandom};
        w   = (it.width_mode == itoa_pkg::WMODE_16) ? 16 :
              (it.width_mode == itoa_pkg::WMODE_32) ? 32 : 64;
        msb = 64'd1 << (w - 1);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: it.number = noise;
            5, 6, 7:       it.number = 64'($urandom_range(99999));
            default:
            begin
                case ($urandom_range(3))
                    0:       it.number = msb;
                    1:       it.number = msb - 64'd1;
                    2:       it.number = '1;
                    default: it.number = 64'd0;
                endcase
                // junk above the operand width must not matter
                if (w < 64 && $urandom_range(1) == 1)
                    it.number |= noise & ~((64'd1 << w) - 64'd1);
            end
        endcase
        return it;
    endfunction

    // Presents one number; start is redrawn every cycle until the beat is taken.
    task automatic send_number(itoa_pkg::item_t it, int idle_pct);
        logic taken;
        taken = 1'b0;
        item  <= it;
        start <= ($urandom_range(99) >= idle_pct);
        while (!taken)
        begin
            @(posedge clk);
            if (start && !busy)
            begin
                tracker.note_number(it);
                taken = 1'b1;
            end
            else
            begin
                start <= ($urandom_range(99) >= idle_pct);
            end
        end
    endtask

    task automatic send_random(int idle_pct);
        itoa_pkg::item_t it;
        int    counted;
        counted = 0;
        while (counted < PHASE_ITEMS)
        begin
            it = random_item();
            send_number(it, idle_pct);
            if (it.func != itoa_pkg::FUNC_NONE)
                counted++;
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero at every width and format
        for (int f = 0; f < 3; f++)
            for (int wm = 0; wm < 3; wm++)
                send_number(make_item(2'(f), 2'(wm), 64'd0), IDLE_LOW);
        // most negative values and other edge values
        send_number(make_item(itoa_pkg::FUNC_SDEC, itoa_pkg::WMODE_16,
                              64'h0000_0000_0000_8000), IDLE_LOW);
        send_number(make_item(itoa_pkg::FUNC_SDEC, itoa_pkg::WMODE_32,
                              64'h0000_0000_8000_0000), IDLE_LOW);
        send_number(make_item(itoa_pkg::FUNC_SDEC, WMODE_64, 64'h8000_0000_0000_0000),
                    IDLE_LOW);
        send_number(make_item(itoa_pkg::FUNC_SDEC, WMODE_64, 64'h7FFF_FFFF_FFFF_FFFF),
                    IDLE_LOW);
        send_number(make_item(itoa_pkg::FUNC_SDEC, itoa_pkg::WMODE_16,
                              64'hFFFF_FFFF_FFFF_FFFF), IDLE_LOW);
        send_number(make_item(itoa_pkg::FUNC_UDEC, WMODE_64, 64'hFFFF_FFFF_FFFF_FFFF),
                    IDLE_LOW);
        send_number(make_item(itoa_pkg::FUNC_HEX, WMODE_64, 64'hFFFF_FFFF_FFFF_FFFF),
                    IDLE_LOW);
        send_number(make_item(itoa_pkg::FUNC_UDEC, itoa_pkg::WMODE_16,
                              64'hABCD_1234_5678_8000), IDLE_LOW);
        send_number(make_item(itoa_pkg::FUNC_HEX, itoa_pkg::WMODE_32,
                              64'h1234_5678_DEAD_BEEF), IDLE_LOW);
        send_number(make_item(itoa_pkg::FUNC_SDEC, itoa_pkg::WMODE_32,
                              64'hFFFF_FFFF_7FFF_FFFF), IDLE_LOW);
        send_number(make_item(itoa_pkg::FUNC_UDEC, itoa_pkg::WMODE_32, 64'd9), IDLE_LOW);
        send_number(make_item(itoa_pkg::FUNC_UDEC, itoa_pkg::WMODE_32, 64'd10), IDLE_LOW);
        // unused format code gives no text; reserved width acts as 64 bits
        send_number(make_item(itoa_pkg::FUNC_NONE, WMODE_64, 64'h0123_4567_89AB_CDEF),
                    IDLE_LOW);
        send_number(make_item(itoa_pkg::FUNC_SDEC, WMODE_RSVD, 64'hFEDC_BA98_7654_3210),
                    IDLE_LOW);
        send_number(make_item(itoa_pkg::FUNC_HEX, WMODE_RSVD, 64'h0FED_CBA9_8765_4321),
                    IDLE_LOW);

        send_random(IDLE_LOW);
        send_random(IDLE_HIGH);
        send_random(IDLE_NONE);
        start <= 1'b0;

        while (tracker.pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending_chars.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
